// ----- hw/rtl/sle_pkg.sv -----
// shared types, widths and codes for the sorted linked list engine
package sle_pkg;

  // default node store depth
  localparam int NODES_DEF    = 16;

  // payload field widths
  localparam int CMD_W        = 2;
  localparam int VALUE_W      = 32;
  localparam int LIST_COUNT_W = 5;

  // command codes carried on the input beat
  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_DUMP   = 2'd2
  } cmd_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // input beat
  typedef struct packed {
    logic [CMD_W-1:0]          command;
    logic signed [VALUE_W-1:0] value;
  } in_beat_t;

  // result beat
  typedef struct packed {
    status_t                   status;
    logic signed [VALUE_W-1:0] element;
    logic [LIST_COUNT_W-1:0]   list_count;
    logic                      last;
  } out_beat_t;

  // how the splice neighbors p and q get loaded
  typedef enum logic [2:0] {
    PQ_HOLD,
    PQ_NIL_NIL,
    PQ_NIL_HEAD,
    PQ_CUR_NIL,
    PQ_PREV_CUR,
    PQ_PREV_NEXT
  } pq_sel_t;

  // controller to datapath commands
  typedef struct packed {
    logic    latch;       // capture the input beat
    logic    rd_head;     // read node store at the head
    logic    rd_next;     // read node store at the current node's next link
    logic    pop;         // take a node from the free stack, write its value
    pq_sel_t pq;          // load splice neighbors
    logic    link_new;    // write links of the new node
    logic    splice_ins;  // hook the new node into its neighbors
    logic    splice_del;  // unhook the current node, push it on the free stack
    logic    load_out;    // load the output register
    status_t status;      // status of the loaded result
    logic    out_elem;    // result element comes from the node read
    logic    out_last;    // result closes the item
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             head_nil;
    logic             top_zero;
    logic             val_lt;
    logic             val_le;
    logic             val_eq;
    logic             nxt_nil;
    logic             out_free;
  } dp_status_t;

endpackage

// ----- hw/rtl/sle_datapath.sv -----
// node store, free stack, list registers and output register of the list engine
module sle_datapath
  import sle_pkg::*;
#(
  parameter int NODES = NODES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  in_beat_t   in_data,
  input  dp_cmd_t    cmd,
  output dp_status_t sts,
  output logic       out_valid,
  input  logic       out_stall,
  output out_beat_t  out_data
);

  localparam int IW = $clog2(NODES + 1);
  localparam int AW = $clog2(NODES);
  localparam logic [IW-1:0] NIL = IW'(NODES);

  // latched item
  logic [CMD_W-1:0]          cmd_r;
  logic signed [VALUE_W-1:0] x_r;

  // list control registers
  logic [IW-1:0] head_r;
  logic [IW-1:0] top_r;
  logic [IW-1:0] low_r;
  logic [IW-1:0] count_r;

  // walk and splice registers
  logic [IW-1:0] cur_r;
  logic [AW-1:0] n_r;
  logic [IW-1:0] p_r;
  logic [IW-1:0] q_r;

  // memories and their read registers
  logic signed [VALUE_W-1:0] val_mem [NODES];
  logic [IW-1:0]             nxt_mem [NODES];
  logic [IW-1:0]             prv_mem [NODES];
  logic [AW-1:0]             fs_mem  [NODES];

  logic signed [VALUE_W-1:0] val_rd_r;
  logic [IW-1:0]             nxt_rd_r;
  logic [IW-1:0]             prv_rd_r;
  logic [AW-1:0]             fs_rd_r;
  logic                      fs_init_r;
  logic [AW-1:0]             fs_idx_r;

  // output register
  logic      out_valid_r;
  out_beat_t out_r;

  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] top_m1;
  logic [AW-1:0] n_pick;
  logic [IW-1:0] n_ext;
  logic          nxt_we;
  logic [IW-1:0] nxt_wa;
  logic [IW-1:0] nxt_wd;
  logic          prv_we;
  logic [IW-1:0] prv_wa;
  logic [IW-1:0] prv_wd;
  logic          out_free;

  assign rd_en    = cmd.rd_head | cmd.rd_next;
  assign rd_addr  = cmd.rd_head ? head_r : nxt_rd_r;
  assign top_m1   = top_r - IW'(1);
  // entries below the low-water mark were never written, so their own index stands in for them
  assign n_pick   = fs_init_r ? fs_idx_r : fs_rd_r;
  assign n_ext    = IW'(n_r);
  assign out_free = !out_valid_r || !out_stall;

  // link write ports
  always_comb begin
    nxt_we = 1'b0;
    nxt_wa = n_ext;
    nxt_wd = q_r;
    prv_we = 1'b0;
    prv_wa = n_ext;
    prv_wd = p_r;
    if (cmd.link_new) begin
      nxt_we = 1'b1;
      prv_we = 1'b1;
    end else if (cmd.splice_ins) begin
      nxt_we = (p_r != NIL);
      nxt_wa = p_r;
      nxt_wd = n_ext;
      prv_we = (q_r != NIL);
      prv_wa = q_r;
      prv_wd = n_ext;
    end else if (cmd.splice_del) begin
      nxt_we = (p_r != NIL);
      nxt_wa = p_r;
      nxt_wd = q_r;
      prv_we = (q_r != NIL);
      prv_wa = q_r;
      prv_wd = p_r;
    end
  end

  // node store read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      val_rd_r <= val_mem[rd_addr[AW-1:0]];
      nxt_rd_r <= nxt_mem[rd_addr[AW-1:0]];
      prv_rd_r <= prv_mem[rd_addr[AW-1:0]];
      cur_r    <= rd_addr;
    end
  end

  // node store write ports
  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      val_mem[n_pick] <= x_r;
    end
    if (nxt_we) begin
      nxt_mem[nxt_wa[AW-1:0]] <= nxt_wd;
    end
    if (prv_we) begin
      prv_mem[prv_wa[AW-1:0]] <= prv_wd;
    end
  end

  // free stack: read at the top entry whenever the stack is not empty, push on delete
  always_ff @(posedge clk) begin
    if (top_r != '0) begin
      fs_rd_r   <= fs_mem[top_m1[AW-1:0]];
      fs_init_r <= (top_m1 < low_r);
      fs_idx_r  <= top_m1[AW-1:0];
    end
    if (cmd.splice_del) begin
      fs_mem[top_r[AW-1:0]] <= cur_r[AW-1:0];
    end
  end

  // item and splice payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cmd_r <= in_data.command;
      x_r   <= in_data.value;
    end
    if (cmd.pop) begin
      n_r <= n_pick;
    end
    case (cmd.pq)
      PQ_NIL_NIL: begin
        p_r <= NIL;
        q_r <= NIL;
      end
      PQ_NIL_HEAD: begin
        p_r <= NIL;
        q_r <= head_r;
      end
      PQ_CUR_NIL: begin
        p_r <= cur_r;
        q_r <= NIL;
      end
      PQ_PREV_CUR: begin
        p_r <= prv_rd_r;
        q_r <= cur_r;
      end
      PQ_PREV_NEXT: begin
        p_r <= prv_rd_r;
        q_r <= nxt_rd_r;
      end
      default: begin
      end
    endcase
  end

  // list control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= NIL;
      top_r   <= NIL;
      low_r   <= NIL;
      count_r <= '0;
    end else begin
      if (cmd.pop) begin
        top_r <= top_m1;
        if (top_m1 < low_r) begin
          low_r <= top_m1;
        end
      end
      if (cmd.splice_ins) begin
        count_r <= count_r + IW'(1);
        if (p_r == NIL) begin
          head_r <= n_ext;
        end
      end
      if (cmd.splice_del) begin
        count_r <= count_r - IW'(1);
        top_r   <= top_r + IW'(1);
        if (p_r == NIL) begin
          head_r <= q_r;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r.status     <= cmd.status;
      out_r.element    <= cmd.out_elem ? val_rd_r : '0;
      out_r.list_count <= LIST_COUNT_W'(count_r);
      out_r.last       <= cmd.out_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // status toward the controller
  assign sts.cmd      = cmd_r;
  assign sts.head_nil = (head_r == NIL);
  assign sts.top_zero = (top_r == '0);
  assign sts.val_lt   = (val_rd_r < x_r);
  assign sts.val_le   = (val_rd_r <= x_r);
  assign sts.val_eq   = (val_rd_r == x_r);
  assign sts.nxt_nil  = (nxt_rd_r == NIL);
  assign sts.out_free = out_free;

endmodule

// ----- hw/rtl/sle_ctrl.sv -----
// sequencing state machine of the list engine
module sle_ctrl
  import sle_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t sts,
  output dp_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_POP,
    S_WALK_INS,
    S_LINK1,
    S_LINK2,
    S_WALK_DEL,
    S_UNLINK,
    S_DUMP,
    S_EMIT
  } state_t;

  state_t  state_r;
  state_t  state_nxt;
  status_t st_r;
  status_t st_nxt;

  // state and pending status
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      st_r    <= ST_OK;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  // next state and datapath commands
  always_comb begin
    state_nxt      = state_r;
    st_nxt         = st_r;
    cmd            = '0;
    cmd.pq         = PQ_HOLD;
    cmd.status     = ST_OK;
    case (state_r)
      S_IDLE: begin
        cmd.latch = in_valid;
        if (in_valid) begin
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        case (sts.cmd)
          CMD_INSERT: begin
            if (sts.top_zero) begin
              st_nxt    = ST_FULL;
              state_nxt = S_EMIT;
            end else begin
              cmd.rd_head = !sts.head_nil;
              state_nxt   = S_POP;
            end
          end
          CMD_DELETE: begin
            if (sts.head_nil) begin
              st_nxt    = ST_EMPTY;
              state_nxt = S_EMIT;
            end else begin
              cmd.rd_head = 1'b1;
              state_nxt   = S_WALK_DEL;
            end
          end
          CMD_DUMP: begin
            if (sts.head_nil) begin
              st_nxt    = ST_EMPTY;
              state_nxt = S_EMIT;
            end else begin
              cmd.rd_head = 1'b1;
              state_nxt   = S_DUMP;
            end
          end
          default: begin
            st_nxt    = ST_OK;
            state_nxt = S_EMIT;
          end
        endcase
      end

      // take a free node; an empty list or a head not below the value goes in front
      S_POP: begin
        cmd.pop = 1'b1;
        if (sts.head_nil) begin
          cmd.pq    = PQ_NIL_NIL;
          state_nxt = S_LINK1;
        end else if (!sts.val_lt) begin
          cmd.pq    = PQ_NIL_HEAD;
          state_nxt = S_LINK1;
        end else begin
          state_nxt = S_WALK_INS;
        end
      end

      // one node per cycle until a greater value or the tail
      S_WALK_INS: begin
        if (sts.val_le && !sts.nxt_nil) begin
          cmd.rd_next = 1'b1;
        end else if (sts.val_le) begin
          cmd.pq    = PQ_CUR_NIL;
          state_nxt = S_LINK1;
        end else begin
          cmd.pq    = PQ_PREV_CUR;
          state_nxt = S_LINK1;
        end
      end

      S_LINK1: begin
        cmd.link_new = 1'b1;
        state_nxt    = S_LINK2;
      end

      S_LINK2: begin
        cmd.splice_ins = 1'b1;
        st_nxt         = ST_OK;
        state_nxt      = S_EMIT;
      end

      // one node per cycle until a match or the tail
      S_WALK_DEL: begin
        if (sts.val_eq) begin
          cmd.pq    = PQ_PREV_NEXT;
          state_nxt = S_UNLINK;
        end else if (!sts.nxt_nil) begin
          cmd.rd_next = 1'b1;
        end else begin
          st_nxt    = ST_NOT_FOUND;
          state_nxt = S_EMIT;
        end
      end

      S_UNLINK: begin
        cmd.splice_del = 1'b1;
        st_nxt         = ST_OK;
        state_nxt      = S_EMIT;
      end

      // one beat per element, waiting on the output register
      S_DUMP: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          cmd.status   = ST_OK;
          cmd.out_elem = 1'b1;
          cmd.out_last = sts.nxt_nil;
          if (sts.nxt_nil) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.rd_next = 1'b1;
          end
        end
      end

      S_EMIT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          cmd.status   = st_r;
          cmd.out_last = 1'b1;
          state_nxt    = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/sorted_linked_list_engine.sv -----
// top level of the sorted linked list engine
//
// Keeps an ascending list of signed 32-bit values in a store of NODES nodes.
// Input channel (in_valid, in_stall, in_data): one beat per command, insert,
// delete or dump. Result channel (out_valid, out_stall, out_data): insert,
// delete and unknown commands give one beat; a dump gives one beat per element
// in ascending order, or one empty-status beat. The final beat of a command has
// last set, and every beat carries the list size after the command.
// The insert and delete walks read one node per cycle from the node store.
// Full, empty and unknown commands are answered without a walk, and a dump
// delivers one element per cycle while out_stall is low. One command is
// worked on at a time; in_stall is low only between commands, from the cycle
// after the final beat is loaded, and that beat may still be waiting.
// When out_stall is high the result register holds its beat and the engine
// waits before loading the next one.
// Reset (rst_n low, synchronous) empties the list and frees every node; no
// clearing pass is needed.
module sorted_linked_list_engine
  import sle_pkg::*;
#(
  parameter int NODES = NODES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  dp_cmd_t    cmd;
  dp_status_t sts;

  // sequencing
  sle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // storage and result register
  sle_datapath #(
    .NODES (NODES)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- tb/tb_sorted_linked_list_engine.sv -----
// self-checking testbench for the sorted linked list engine
module tb_sorted_linked_list_engine;
  import sle_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODES       = NODES_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 2 * NODES + 20;

  // command code with no operation behind it, answered by a plain ok beat
  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

  localparam logic signed [VALUE_W-1:0] MAXV = 32'sh7FFF_FFFF;
  localparam logic signed [VALUE_W-1:0] MINV = 32'sh8000_0000;

  typedef struct {
    logic [CMD_W-1:0]          cmd;
    logic signed [VALUE_W-1:0] value;
    bit                        typed;
    status_t                   st;
    int                        cnt;
  } script_row_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_beat_t out_data;

  // list contents as the engine should hold them, ascending
  logic signed [VALUE_W-1:0] sorted_vals[$];
  // beats caused by the last command, and beats still owed by the engine
  out_beat_t step_beats[$];
  out_beat_t pending_beats[$];

  int errors = 0;
  int cycle = 0;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  script_row_t script[24];

  sorted_linked_list_engine DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #1ns clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle++;
    if (cycle >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats pending", cycle, pending_beats.size());
      $display("tb_sorted_linked_list_engine: done, errors");
      $finish;
    end
  end

  task automatic report(string msg);
    $display("mismatch at cycle %0d: %s", cycle, msg);
    errors++;
  endtask

  // apply one command to the list, collect the beats it causes
  function automatic void list_apply(in_beat_t b);
    int pos;
    out_beat_t r;
    step_beats = {};
    r = '0;
    r.status = ST_OK;
    r.last = 1'b1;
    case (b.command)
      CMD_INSERT: begin
        if (sorted_vals.size() >= NODES) begin
          r.status = ST_FULL;
        end else begin
          // equal values land after existing ones; indistinguishable from outside
          pos = 0;
          while (pos < sorted_vals.size() && sorted_vals[pos] <= b.value) pos++;
          sorted_vals.insert(pos, b.value);
        end
      end
      CMD_DELETE: begin
        if (sorted_vals.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          pos = 0;
          while (pos < sorted_vals.size() && sorted_vals[pos] != b.value) pos++;
          if (pos == sorted_vals.size()) r.status = ST_NOT_FOUND;
          else sorted_vals.delete(pos);
        end
      end
      CMD_DUMP: begin
        if (sorted_vals.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          // one beat per element, last on the tail
          for (int i = 0; i < sorted_vals.size(); i++) begin
            r.element = sorted_vals[i];
            r.list_count = LIST_COUNT_W'(sorted_vals.size());
            r.last = (i == sorted_vals.size() - 1);
            step_beats.push_back(r);
          end
          return;
        end
      end
      default: ;
    endcase
    r.list_count = LIST_COUNT_W'(sorted_vals.size());
    step_beats.push_back(r);
  endfunction

  function automatic in_beat_t beat_of(logic [CMD_W-1:0] cmd, logic signed [VALUE_W-1:0] v);
    in_beat_t b;
    b.command = cmd;
    b.value = v;
    return b;
  endfunction

  // often a narrow band so that duplicates and hits are common, else extremes or any value
  function automatic logic signed [VALUE_W-1:0] rand_value();
    case ($urandom_range(9))
      0, 1, 2, 3: return $signed($urandom_range(16)) - 8;
      4:          return MINV;
      5:          return MAXV;
      default:    return $urandom;
    endcase
  endfunction

  // drive one beat at the falling edge, hold it until taken, then predict
  task automatic send_beat(in_beat_t b, bit typed = 1'b0, status_t st = ST_OK, int cnt = 0);
    out_beat_t r;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = b;
    do @(posedge clk); while (in_stall);
    list_apply(b);
    if (typed) begin
      r = '0;
      r.status = st;
      r.list_count = LIST_COUNT_W'(cnt);
      r.last = 1'b1;
      pending_beats.push_back(r);
    end else begin
      foreach (step_beats[i]) pending_beats.push_back(step_beats[i]);
    end
    @(negedge clk);
  endtask

  task automatic send_random_op();
    int pick;
    pick = $urandom_range(99);
    if (pick < 45) begin
      send_beat(beat_of(CMD_INSERT, rand_value()));
    end else if (pick < 80) begin
      if (sorted_vals.size() != 0 && $urandom_range(1))
        send_beat(beat_of(CMD_DELETE, sorted_vals[$urandom_range(sorted_vals.size() - 1)]));
      else
        send_beat(beat_of(CMD_DELETE, rand_value()));
    end else if (pick < 95) begin
      send_beat(beat_of(CMD_DUMP, $urandom));
    end else begin
      send_beat(beat_of(CMD_NOP, $urandom));
    end
  endtask

  // receiver back-pressure
  always @(negedge clk) begin
    if (rst_n) out_stall = ($urandom_range(99) < sink_stall_pct);
  end

  // result checker
  always @(posedge clk) begin : result_check
    out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_beats.size() == 0) begin
        report($sformatf("unexpected result beat status %0d element %0d",
                         out_data.status, out_data.element));
      end else begin
        want = pending_beats.pop_front();
        if (out_data.status !== want.status)
          report($sformatf("status got %0d want %0d", out_data.status, want.status));
        if (out_data.element !== want.element)
          report($sformatf("element got %0d want %0d", out_data.element, want.element));
        if (out_data.list_count !== want.list_count)
          report($sformatf("list_count got %0d want %0d",
                           out_data.list_count, want.list_count));
        if (out_data.last !== want.last)
          report($sformatf("last got %0b want %0b", out_data.last, want.last));
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;

    // directed walk: empty list, extremes, duplicates at head and middle, errors
    script = '{
      '{CMD_DUMP,   0,             1, ST_EMPTY,     0},
      '{CMD_DELETE, 5,             1, ST_EMPTY,     0},
      '{CMD_NOP,    0,             1, ST_OK,        0},
      '{CMD_INSERT, MAXV,          1, ST_OK,        1},
      '{CMD_INSERT, MINV,          1, ST_OK,        2},
      '{CMD_INSERT, 0,             1, ST_OK,        3},
      '{CMD_INSERT, 0,             1, ST_OK,        4},
      '{CMD_INSERT, MINV,          1, ST_OK,        5},
      '{CMD_INSERT, -1,            1, ST_OK,        6},
      '{CMD_DUMP,   0,             0, ST_OK,        0},
      '{CMD_DELETE, 12345,         1, ST_NOT_FOUND, 6},
      '{CMD_DELETE, MAXV,          1, ST_OK,        5},
      '{CMD_DELETE, MINV,          1, ST_OK,        4},
      '{CMD_DELETE, 0,             1, ST_OK,        3},
      '{CMD_NOP,    -1,            1, ST_OK,        3},
      '{CMD_DUMP,   0,             0, ST_OK,        0},
      '{CMD_DELETE, MINV,          1, ST_OK,        2},
      '{CMD_DELETE, 0,             1, ST_OK,        1},
      '{CMD_DELETE, -1,            1, ST_OK,        0},
      '{CMD_DELETE, -1,            1, ST_EMPTY,     0},
      '{CMD_DUMP,   0,             1, ST_EMPTY,     0},
      '{CMD_INSERT, 32'sh5555_5555, 1, ST_OK,       1},
      '{CMD_INSERT, 32'shAAAA_AAAA, 1, ST_OK,       2},
      '{CMD_DUMP,   0,             0, ST_OK,        0}
    };

    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    foreach (script[i])
      send_beat(beat_of(script[i].cmd, script[i].value), script[i].typed,
                script[i].st, script[i].cnt);

    // random phases: fill to full, drain to empty, then a free mix
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 88; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 88; end
        default: begin src_idle_pct = 12; sink_stall_pct = 12; end
      endcase
      while (sorted_vals.size() < NODES)
        send_beat(beat_of(CMD_INSERT, rand_value()));
      repeat (2) send_beat(beat_of(CMD_INSERT, rand_value()));
      send_beat(beat_of(CMD_DUMP, $urandom));
      while (sorted_vals.size() != 0) begin
        if ($urandom_range(5) == 0)
          send_beat(beat_of(CMD_DELETE, rand_value()));
        else
          send_beat(beat_of(CMD_DELETE, sorted_vals[$urandom_range(sorted_vals.size() - 1)]));
      end
      send_beat(beat_of(CMD_DELETE, rand_value()));
      send_beat(beat_of(CMD_DUMP, $urandom));
      repeat (20) send_random_op();
    end
    in_valid = 1'b0;

    // let the engine finish what it owes
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (errors == 0)
      $display("tb_sorted_linked_list_engine: done, clean");
    else
      $display("tb_sorted_linked_list_engine: done, errors");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/sle_pkg.sv
hw/rtl/sle_datapath.sv
hw/rtl/sle_ctrl.sv
hw/rtl/sorted_linked_list_engine.sv
tb/tb_sorted_linked_list_engine.sv
